// File: rtl/pixel_format_converter_assert.svh
// ----------------------------------------------------------------------------
// Pixel format converter assertion macros
// Shared property wrappers for the checker of the pixel format converter.
// ----------------------------------------------------------------------------
`ifndef PIXEL_FORMAT_CONVERTER_ASSERT_SVH
`define PIXEL_FORMAT_CONVERTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define PFC_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
   else $error("pixel format converter check failed");

// Next-cycle implication, disabled while reset is high.
`define PFC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
   else $error("pixel format converter check failed");

// Same-cycle implication that also holds through reset.
`define PFC_ASSERT_UNGATED(lbl, clk, ante, cons) \
lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
   else $error("pixel format converter check failed");

`endif

// File: rtl/pfc_pkg.sv
// ----------------------------------------------------------------------------
// Pixel format converter package
// Mode codes, payload types, expansion tables and conversion functions.
// ----------------------------------------------------------------------------
package pfc_pkg;

   typedef enum logic [2:0] {
      KIND_555_TO_RGB,
      KIND_565_TO_RGB,
      KIND_RGB_TO_565,
      KIND_RGB_TO_555,
      KIND_555_TO_565,
      KIND_4444_TO_RGBA,
      KIND_RGBA_TO_4444
   } kind_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] packed_in;
      logic [7:0]  red_in;
      logic [7:0]  green_in;
      logic [7:0]  blue_in;
      logic [7:0]  alpha_in;
   } pix_in_type;

   typedef struct packed {
      logic [15:0] packed_out;
      logic [7:0]  red_out;
      logic [7:0]  green_out;
      logic [7:0]  blue_out;
      logic [7:0]  alpha_out;
   } pix_out_type;

   localparam logic [7:0] EXP5 [32] = '{
      8'd0,   8'd8,   8'd16,  8'd25,  8'd33,  8'd41,  8'd49,  8'd58,
      8'd66,  8'd74,  8'd82,  8'd90,  8'd99,  8'd107, 8'd115, 8'd123,
      8'd132, 8'd140, 8'd148, 8'd156, 8'd165, 8'd173, 8'd181, 8'd189,
      8'd197, 8'd206, 8'd214, 8'd222, 8'd230, 8'd239, 8'd247, 8'd255
   };

   localparam logic [7:0] EXP6 [64] = '{
      8'd0,   8'd4,   8'd8,   8'd12,  8'd16,  8'd20,  8'd24,  8'd28,
      8'd32,  8'd36,  8'd40,  8'd45,  8'd49,  8'd53,  8'd57,  8'd61,
      8'd65,  8'd69,  8'd73,  8'd77,  8'd81,  8'd85,  8'd89,  8'd93,
      8'd97,  8'd101, 8'd105, 8'd109, 8'd113, 8'd117, 8'd121, 8'd125,
      8'd130, 8'd134, 8'd138, 8'd142, 8'd146, 8'd150, 8'd154, 8'd158,
      8'd162, 8'd166, 8'd170, 8'd174, 8'd178, 8'd182, 8'd186, 8'd190,
      8'd194, 8'd198, 8'd202, 8'd206, 8'd210, 8'd215, 8'd219, 8'd223,
      8'd227, 8'd231, 8'd235, 8'd239, 8'd243, 8'd247, 8'd251, 8'd255
   };

   // Reciprocals: x/31 = (x*RECIP31) >> 20 for x < 8192, x/17 = (x*RECIP17) >> 12 for x < 256.
   localparam logic [15:0] RECIP31 = 16'd33826;
   localparam logic [7:0]  RECIP17 = 8'd241;

   // Largest index whose table entry does not exceed the channel value.
   function automatic logic [4:0] quant5(input logic [7:0] v);
      logic [4:0] idx;
      idx = '0;
      for (int i = 1; i < 32; i++) begin
         if (EXP5[i] <= v) begin
            idx = 5'(i);
         end
      end
      return idx;
   endfunction

   function automatic logic [5:0] quant6(input logic [7:0] v);
      logic [5:0] idx;
      idx = '0;
      for (int i = 1; i < 64; i++) begin
         if (EXP6[i] <= v) begin
            idx = 6'(i);
         end
      end
      return idx;
   endfunction

   // Expands a 5-bit field as c*255/31 with truncation.
   function automatic logic [7:0] scale31(input logic [4:0] c);
      logic [12:0] prod;
      logic [28:0] scaled;
      prod   = 13'(c) * 13'd255;
      scaled = 29'(prod) * 29'(RECIP31);
      return scaled[27:20];
   endfunction

   // Reduces an 8-bit channel as c*15/255, which equals c/17.
   function automatic logic [3:0] div17(input logic [7:0] c);
      logic [15:0] prod;
      prod = 16'(c) * 16'(RECIP17);
      return prod[15:12];
   endfunction

endpackage

// File: rtl/pfc_convert.sv
// ----------------------------------------------------------------------------
// Pixel format converter datapath
// Combinational conversion of one registered pixel into its result fields.
// ----------------------------------------------------------------------------
module pfc_convert (
   input  pfc_pkg::pix_in_type  item,
   output pfc_pkg::pix_out_type result
);

   pfc_pkg::kind_type kind;
   logic [15:0]       pk;
   logic [7:0]        r8_555;
   logic [7:0]        g8_555;
   logic [7:0]        b8_555;

   assign kind   = pfc_pkg::kind_type'(item.kind);
   assign pk     = item.packed_in;
   assign r8_555 = pfc_pkg::scale31(pk[4:0]);
   assign g8_555 = pfc_pkg::scale31(pk[9:5]);
   assign b8_555 = pfc_pkg::scale31(pk[14:10]);

   always_comb begin
      result = '0;
      case (kind)
         pfc_pkg::KIND_555_TO_RGB: begin
            result.red_out   = pfc_pkg::EXP5[pk[4:0]];
            result.green_out = pfc_pkg::EXP5[pk[9:5]];
            result.blue_out  = pfc_pkg::EXP5[pk[14:10]];
         end
         pfc_pkg::KIND_565_TO_RGB: begin
            result.red_out   = pfc_pkg::EXP5[pk[4:0]];
            result.green_out = pfc_pkg::EXP6[pk[10:5]];
            result.blue_out  = pfc_pkg::EXP5[pk[15:11]];
         end
         pfc_pkg::KIND_RGB_TO_565: begin
            result.packed_out = {pfc_pkg::quant5(item.blue_in),
                                 pfc_pkg::quant6(item.green_in),
                                 pfc_pkg::quant5(item.red_in)};
         end
         pfc_pkg::KIND_RGB_TO_555: begin
            result.packed_out = {1'b0,
                                 pfc_pkg::quant5(item.blue_in),
                                 pfc_pkg::quant5(item.green_in),
                                 pfc_pkg::quant5(item.red_in)};
         end
         pfc_pkg::KIND_555_TO_565: begin
            result.packed_out = {pfc_pkg::quant5(b8_555),
                                 pfc_pkg::quant6(g8_555),
                                 pfc_pkg::quant5(r8_555)};
         end
         pfc_pkg::KIND_4444_TO_RGBA: begin
            result.red_out   = {pk[3:0], pk[3:0]};
            result.green_out = {pk[7:4], pk[7:4]};
            result.blue_out  = {pk[11:8], pk[11:8]};
            result.alpha_out = {pk[15:12], pk[15:12]};
         end
         pfc_pkg::KIND_RGBA_TO_4444: begin
            result.packed_out = {pfc_pkg::div17(item.alpha_in),
                                 pfc_pkg::div17(item.blue_in),
                                 pfc_pkg::div17(item.green_in),
                                 pfc_pkg::div17(item.red_in)};
         end
         default: begin
            result = '0;
         end
      endcase
   end

endmodule

// File: rtl/pixel_format_converter.sv
// ----------------------------------------------------------------------------
// Pixel format converter
// Converts one pixel per transfer among 16-bit packed formats and 8-bit channels.
// ----------------------------------------------------------------------------
// Each result passes through the input register and then the result register.
// Throughput: one pixel per cycle unless stalled, set by the register pair.
// A stalled result lets an empty input register fill, then each holds one pixel.
// Reset clears both valid flags; payload registers are not reset.
module pixel_format_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_kind,
   input  logic [15:0] req_packed_in,
   input  logic [7:0]  req_red_in,
   input  logic [7:0]  req_green_in,
   input  logic [7:0]  req_blue_in,
   input  logic [7:0]  req_alpha_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_packed_out,
   output logic [7:0]  rsp_red_out,
   output logic [7:0]  rsp_green_out,
   output logic [7:0]  rsp_blue_out,
   output logic [7:0]  rsp_alpha_out
);

   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   pfc_pkg::pix_in_type  s1_item_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   pfc_pkg::pix_out_type rsp_item_ff;
   pfc_pkg::pix_out_type conv_result;
   logic                 advance;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || advance;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (req_ready) begin
         s1_valid_in = req_valid;
      end
      if (advance) begin
         rsp_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_item_ff <= '{kind:      req_kind,
                         packed_in: req_packed_in,
                         red_in:    req_red_in,
                         green_in:  req_green_in,
                         blue_in:   req_blue_in,
                         alpha_in:  req_alpha_in};
      end
      if (advance && s1_valid_ff) begin
         rsp_item_ff <= conv_result;
      end
   end

   pfc_convert u_convert (
      .item   (s1_item_ff),
      .result (conv_result)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_packed_out = rsp_item_ff.packed_out;
   assign rsp_red_out    = rsp_item_ff.red_out;
   assign rsp_green_out  = rsp_item_ff.green_out;
   assign rsp_blue_out   = rsp_item_ff.blue_out;
   assign rsp_alpha_out  = rsp_item_ff.alpha_out;

endmodule

// File: rtl/pfc_checker.sv
// ----------------------------------------------------------------------------
// Pixel format converter checker
// Port-level assertions on the converter, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "pixel_format_converter_assert.svh"

module pfc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_packed_out,
   input logic [7:0]  rsp_red_out,
   input logic [7:0]  rsp_green_out,
   input logic [7:0]  rsp_blue_out,
   input logic [7:0]  rsp_alpha_out
);

   logic channels_zero;
   logic packed_zero;
   logic alpha_set;
   logic nibbles_match;

   assign channels_zero = (rsp_red_out == 8'd0) && (rsp_green_out == 8'd0) &&
                          (rsp_blue_out == 8'd0) && (rsp_alpha_out == 8'd0);
   assign packed_zero   = (rsp_packed_out == 16'd0);
   assign alpha_set     = (rsp_alpha_out != 8'd0);
   assign nibbles_match = (rsp_red_out[7:4] == rsp_red_out[3:0]) &&
                          (rsp_blue_out[7:4] == rsp_blue_out[3:0]);

   `PFC_ASSERT_UNGATED(a_idle_after_reset, clock, $past(reset), !rsp_valid)
   `PFC_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `PFC_ASSERT_IMPLIES(a_one_side_only, clock, reset, rsp_valid, packed_zero || channels_zero)
   `PFC_ASSERT_IMPLIES(a_nibble_expand, clock, reset, rsp_valid && alpha_set, nibbles_match)

endmodule

bind pixel_format_converter pfc_checker u_pfc_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_packed_out (rsp_packed_out),
   .rsp_red_out    (rsp_red_out),
   .rsp_green_out  (rsp_green_out),
   .rsp_blue_out   (rsp_blue_out),
   .rsp_alpha_out  (rsp_alpha_out)
);

// File: tb/sv/pixel_format_converter_tb.sv
// ----------------------------------------------------------------------------
// Pixel format converter testbench
// Drives directed and random pixels of every mode through the converter and
// checks each result transfer, field by field, against a predictor built
// from the channel expansion rules. The sender and the receiver idle in
// several phases, and one phase holds the receiver off long enough to stall
// the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pixel_format_converter_tb;

   localparam logic [2:0] KIND_UNDEFINED = 3'd7;
   localparam int HOLD_CYCLES = 60;
   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_PHASE_ITEMS = 420;
   localparam int SHOWN_MISMATCHES = 10;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_kind;
   logic [15:0] req_packed_in;
   logic [7:0]  req_red_in;
   logic [7:0]  req_green_in;
   logic [7:0]  req_blue_in;
   logic [7:0]  req_alpha_in;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [15:0] rsp_packed_out;
   logic [7:0]  rsp_red_out;
   logic [7:0]  rsp_green_out;
   logic [7:0]  rsp_blue_out;
   logic [7:0]  rsp_alpha_out;

   pfc_pkg::pix_out_type expected_pixels[$];
   pfc_pkg::pix_out_type observed_pixel;
   int mismatch_count = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_serial = 0;

   pixel_format_converter dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_packed_in  (req_packed_in),
      .req_red_in     (req_red_in),
      .req_green_in   (req_green_in),
      .req_blue_in    (req_blue_in),
      .req_alpha_in   (req_alpha_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_packed_out (rsp_packed_out),
      .rsp_red_out    (rsp_red_out),
      .rsp_green_out  (rsp_green_out),
      .rsp_blue_out   (rsp_blue_out),
      .rsp_alpha_out  (rsp_alpha_out)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("pixel_format_converter regression: fail");
      $finish;
   end

   // An n-bit field expands to round(code * 255 / (2^n - 1)).
   function automatic logic [7:0] level_of(input int code, input int top);
      return 8'((code * 255 + top / 2) / top);
   endfunction

   function automatic int quantize_down(input int channel, input int top);
      int idx;
      idx = 0;
      for (int i = 1; i <= top; i++) begin
         if (level_of(i, top) <= channel) begin
            idx = i;
         end
      end
      return idx;
   endfunction

   function automatic pfc_pkg::pix_out_type convert_pixel(input pfc_pkg::pix_in_type p);
      pfc_pkg::pix_out_type o;
      int red8;
      int green8;
      int blue8;
      o = '0;
      case (p.kind)
         pfc_pkg::KIND_555_TO_RGB: begin
            o.red_out   = level_of(int'(p.packed_in[4:0]), 31);
            o.green_out = level_of(int'(p.packed_in[9:5]), 31);
            o.blue_out  = level_of(int'(p.packed_in[14:10]), 31);
         end
         pfc_pkg::KIND_565_TO_RGB: begin
            o.red_out   = level_of(int'(p.packed_in[4:0]), 31);
            o.green_out = level_of(int'(p.packed_in[10:5]), 63);
            o.blue_out  = level_of(int'(p.packed_in[15:11]), 31);
         end
         pfc_pkg::KIND_RGB_TO_565: begin
            o.packed_out = {5'(quantize_down(int'(p.blue_in), 31)),
                            6'(quantize_down(int'(p.green_in), 63)),
                            5'(quantize_down(int'(p.red_in), 31))};
         end
         pfc_pkg::KIND_RGB_TO_555: begin
            o.packed_out = {1'b0,
                            5'(quantize_down(int'(p.blue_in), 31)),
                            5'(quantize_down(int'(p.green_in), 31)),
                            5'(quantize_down(int'(p.red_in), 31))};
         end
         pfc_pkg::KIND_555_TO_565: begin
            red8   = int'(p.packed_in[4:0]) * 255 / 31;
            green8 = int'(p.packed_in[9:5]) * 255 / 31;
            blue8  = int'(p.packed_in[14:10]) * 255 / 31;
            o.packed_out = {5'(quantize_down(blue8, 31)),
                            6'(quantize_down(green8, 63)),
                            5'(quantize_down(red8, 31))};
         end
         pfc_pkg::KIND_4444_TO_RGBA: begin
            o.red_out   = 8'(int'(p.packed_in[3:0]) * 17);
            o.green_out = 8'(int'(p.packed_in[7:4]) * 17);
            o.blue_out  = 8'(int'(p.packed_in[11:8]) * 17);
            o.alpha_out = 8'(int'(p.packed_in[15:12]) * 17);
         end
         pfc_pkg::KIND_RGBA_TO_4444: begin
            o.packed_out = {4'(int'(p.alpha_in) * 15 / 255),
                            4'(int'(p.blue_in) * 15 / 255),
                            4'(int'(p.green_in) * 15 / 255),
                            4'(int'(p.red_in) * 15 / 255)};
         end
         default: begin
            o = '0;
         end
      endcase
      return o;
   endfunction

   // Channels land on or just below a table level a quarter of the time.
   function automatic logic [7:0] random_channel();
      int top;
      logic [7:0] lvl;
      if ($urandom_range(3) == 0) begin
         top = $urandom_range(1) ? 31 : 63;
         lvl = level_of($urandom_range(top), top);
         return $urandom_range(1) ? lvl : lvl - 8'd1;
      end
      return 8'($urandom);
   endfunction

   function automatic pfc_pkg::pix_in_type random_pixel();
      pfc_pkg::pix_in_type p;
      p.kind      = 3'($urandom_range(7));
      p.packed_in = 16'($urandom);
      p.red_in    = random_channel();
      p.green_in  = random_channel();
      p.blue_in   = random_channel();
      p.alpha_in  = random_channel();
      return p;
   endfunction

   task automatic record_mismatch(input string what, input pfc_pkg::pix_out_type want,
                                  input pfc_pkg::pix_out_type got);
      mismatch_count++;
      if (mismatch_count <= SHOWN_MISMATCHES) begin
         $display("%0t: %s: expected packed=%h r=%h g=%h b=%h a=%h", $realtime, what,
                  want.packed_out, want.red_out, want.green_out, want.blue_out,
                  want.alpha_out);
         $display("%0t: %s: actual   packed=%h r=%h g=%h b=%h a=%h", $realtime, what,
                  got.packed_out, got.red_out, got.green_out, got.blue_out,
                  got.alpha_out);
      end
   endtask

   task automatic send_pixel(input pfc_pkg::pix_in_type p);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_kind      <= p.kind;
      req_packed_in <= p.packed_in;
      req_red_in    <= p.red_in;
      req_green_in  <= p.green_in;
      req_blue_in   <= p.blue_in;
      req_alpha_in  <= p.alpha_in;
      do begin
         @(posedge clock);
      end while (!req_ready);
      expected_pixels.push_back(convert_pixel(p));
   endtask

   task automatic send_fields(input logic [2:0] kind, input logic [15:0] packed_in,
                              input logic [7:0] red, input logic [7:0] green,
                              input logic [7:0] blue, input logic [7:0] alpha);
      send_pixel('{kind, packed_in, red, green, blue, alpha});
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_for_results();
      while (expected_pixels.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic send_random_pixels(input int count);
      repeat (count) begin
         send_pixel(random_pixel());
      end
      stop_sending();
      wait_for_results();
   endtask

   task automatic test_directed_cases();
      send_idle_pct = 0;
      stall_pct = 0;
      send_fields(pfc_pkg::KIND_555_TO_RGB, 16'h0000,
                  8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      send_fields(pfc_pkg::KIND_555_TO_RGB, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_fields(pfc_pkg::KIND_555_TO_RGB, 16'h7FFF, 8'h00, 8'h00, 8'h00, 8'h00);
      send_fields(pfc_pkg::KIND_555_TO_RGB, 16'h8000,
                  8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      send_fields(pfc_pkg::KIND_565_TO_RGB, 16'h0000, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_fields(pfc_pkg::KIND_565_TO_RGB, 16'hFFFF, 8'h00, 8'h00, 8'h00, 8'h00);
      send_fields(pfc_pkg::KIND_565_TO_RGB, 16'h07E0,
                  8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      send_fields(pfc_pkg::KIND_RGB_TO_565, 16'hFFFF, 8'h00, 8'h00, 8'h00, 8'hFF);
      send_fields(pfc_pkg::KIND_RGB_TO_565, 16'h0000, 8'hFF, 8'hFF, 8'hFF, 8'h00);
      send_fields(pfc_pkg::KIND_RGB_TO_565, 16'($urandom), 8'd7, 8'd3, 8'd8,
                  8'($urandom));
      send_fields(pfc_pkg::KIND_RGB_TO_555, 16'hFFFF, 8'h00, 8'h00, 8'h00, 8'hFF);
      send_fields(pfc_pkg::KIND_RGB_TO_555, 16'h0000, 8'hFF, 8'hFF, 8'hFF, 8'h00);
      send_fields(pfc_pkg::KIND_RGB_TO_555, 16'($urandom), 8'd24, 8'd25, 8'd132,
                  8'($urandom));
      send_fields(pfc_pkg::KIND_555_TO_565, 16'h0000, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_fields(pfc_pkg::KIND_555_TO_565, 16'hFFFF, 8'h00, 8'h00, 8'h00, 8'h00);
      send_fields(pfc_pkg::KIND_555_TO_565, 16'h7FFF,
                  8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      send_fields(pfc_pkg::KIND_555_TO_565, 16'h8000,
                  8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      send_fields(pfc_pkg::KIND_4444_TO_RGBA, 16'h0000, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_fields(pfc_pkg::KIND_4444_TO_RGBA, 16'hFFFF, 8'h00, 8'h00, 8'h00, 8'h00);
      send_fields(pfc_pkg::KIND_4444_TO_RGBA, 16'h1234,
                  8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      send_fields(pfc_pkg::KIND_RGBA_TO_4444, 16'hFFFF, 8'h00, 8'h00, 8'h00, 8'h00);
      send_fields(pfc_pkg::KIND_RGBA_TO_4444, 16'h0000, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_fields(pfc_pkg::KIND_RGBA_TO_4444, 16'($urandom), 8'd16, 8'd17, 8'd254,
                  8'd33);
      send_fields(KIND_UNDEFINED, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_fields(KIND_UNDEFINED, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00);
      stop_sending();
      wait_for_results();
   endtask

   task automatic test_random_no_idle();
      send_idle_pct = 0;
      stall_pct = 0;
      send_random_pixels(RANDOM_PHASE_ITEMS);
   endtask

   task automatic test_random_sender_gaps();
      send_idle_pct = 46;
      stall_pct = 0;
      send_random_pixels(RANDOM_PHASE_ITEMS);
   endtask

   task automatic test_random_receiver_stalls();
      send_idle_pct = 0;
      stall_pct = 46;
      send_random_pixels(RANDOM_PHASE_ITEMS);
   endtask

   task automatic test_random_both_idle();
      send_idle_pct = 19;
      stall_pct = 19;
      send_random_pixels(RANDOM_PHASE_ITEMS);
   endtask

   // The receiver holds off while the sender keeps offering pixels, so the
   // pipeline fills and the input stalls; then the sender waits for a drain.
   task automatic test_backpressure();
      send_idle_pct = 0;
      stall_pct = 0;
      hold_serial++;
      send_random_pixels(40);
      hold_serial++;
      send_random_pixels(30);
   endtask

   initial begin
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_serial != hold_seen) begin
            hold_seen = hold_serial;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         observed_pixel = {rsp_packed_out, rsp_red_out, rsp_green_out, rsp_blue_out,
                           rsp_alpha_out};
         if (expected_pixels.size() == 0) begin
            record_mismatch("unexpected result transfer", '0, observed_pixel);
         end else begin
            if (observed_pixel.packed_out !== expected_pixels[0].packed_out ||
                observed_pixel.red_out !== expected_pixels[0].red_out ||
                observed_pixel.green_out !== expected_pixels[0].green_out ||
                observed_pixel.blue_out !== expected_pixels[0].blue_out ||
                observed_pixel.alpha_out !== expected_pixels[0].alpha_out) begin
               record_mismatch("result mismatch", expected_pixels[0], observed_pixel);
            end
            void'(expected_pixels.pop_front());
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = '0;
      req_packed_in = '0;
      req_red_in = '0;
      req_green_in = '0;
      req_blue_in = '0;
      req_alpha_in = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_random_no_idle();
      test_random_sender_gaps();
      test_random_receiver_stalls();
      test_random_both_idle();
      test_backpressure();
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_pixels.size() != 0) begin
         $display("%0d expected results never arrived", expected_pixels.size());
         mismatch_count += expected_pixels.size();
      end
      if (mismatch_count == 0) begin
         $display("pixel_format_converter regression: pass");
      end else begin
         $display("pixel_format_converter regression: fail");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/pfc_pkg.sv
rtl/pfc_convert.sv
rtl/pixel_format_converter.sv
rtl/pfc_checker.sv
tb/sv/pixel_format_converter_tb.sv
